// ----- rtl/core/blr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package blr_pkg;

  localparam int unsigned COORD_W     = 16;
  localparam int unsigned ERR_W       = COORD_W + 2;
  localparam int unsigned SIZE_W      = 15;
  localparam int unsigned COLOR_W     = 32;
  localparam int unsigned CMP_W       = ((COORD_W > SIZE_W) ? COORD_W : SIZE_W) + 1;
  localparam int unsigned S_DATA_W    = ((4 * COORD_W + COLOR_W + 7) / 8) * 8;
  localparam int unsigned M_DATA_W    = ((2 * COORD_W + COLOR_W + 7) / 8) * 8;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SIZE_W-1:0] IMAGE_WIDTH_RST  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] IMAGE_HEIGHT_RST = SIZE_W'(480);

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_e;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_e;

  typedef logic [COORD_W-1:0] coord_t;

  // Classified request as it sits in the queue; deltas already resolved
  typedef struct packed {
    cmd_e               cmd;
    coord_t             start_x;
    coord_t             start_y;
    coord_t             end_x;
    coord_t             end_y;
    coord_t             delta_x;
    coord_t             delta_y;
    logic               dir_x_neg;
    logic               dir_y_neg;
    logic [COLOR_W-1:0] color;
  } blr_cmd_t;

  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
  } blr_bounds_t;

endpackage
`default_nettype wire

// ----- rtl/core/blr_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module blr_front (
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // start_x, start_y, end_x, end_y, line_color (low bits first)
  input  wire logic [blr_pkg::S_DATA_W-1:0]  s_axis_tdata,
  // cmd
  input  wire logic                          s_axis_tuser,
  output logic                               enq_valid_o,
  input  wire logic                          enq_ready_i,
  output blr_pkg::blr_cmd_t                  enq_data_o
);
  import blr_pkg::*;

  coord_t             sx, sy, ex, ey;
  logic signed [COORD_W:0] diff_x, diff_y;

  always_comb begin
    sx = s_axis_tdata[COORD_W-1:0];
    sy = s_axis_tdata[2*COORD_W-1:COORD_W];
    ex = s_axis_tdata[3*COORD_W-1:2*COORD_W];
    ey = s_axis_tdata[4*COORD_W-1:3*COORD_W];

    diff_x = $signed({ex[COORD_W-1], ex}) - $signed({sx[COORD_W-1], sx});
    diff_y = $signed({ey[COORD_W-1], ey}) - $signed({sy[COORD_W-1], sy});

    enq_data_o.cmd       = cmd_e'(s_axis_tuser);
    enq_data_o.start_x   = sx;
    enq_data_o.start_y   = sy;
    enq_data_o.end_x     = ex;
    enq_data_o.end_y     = ey;
    // magnitude fits COORD_W bits unsigned
    enq_data_o.delta_x   = diff_x[COORD_W] ? COORD_W'(-diff_x) : COORD_W'(diff_x);
    enq_data_o.delta_y   = diff_y[COORD_W] ? COORD_W'(-diff_y) : COORD_W'(diff_y);
    enq_data_o.dir_x_neg = !($signed(sx) < $signed(ex));
    enq_data_o.dir_y_neg = !($signed(sy) < $signed(ey));
    enq_data_o.color     = s_axis_tdata[4*COORD_W+COLOR_W-1:4*COORD_W];
  end

  assign enq_valid_o   = s_axis_tvalid;
  assign s_axis_tready = enq_ready_i;

endmodule
`default_nettype wire

// ----- rtl/core/blr_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module blr_queue (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_valid_i,
  output logic              push_ready_o,
  input  blr_pkg::blr_cmd_t push_data_i,
  output logic              pop_valid_o,
  input  wire logic         pop_ready_i,
  output blr_pkg::blr_cmd_t pop_data_o
);
  import blr_pkg::*;

  blr_cmd_t           entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  count_q, count_d;
  logic               push, pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];

  always_comb begin
    push     = push_valid_i && push_ready_o;
    pop      = pop_valid_o && pop_ready_i;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/blr_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module blr_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  blr_pkg::blr_bounds_t               bounds_i,
  input  wire logic                          deq_valid_i,
  output logic                               deq_ready_o,
  input  blr_pkg::blr_cmd_t                  deq_data_i,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // pixel_x, pixel_y, draw_color (low bits first)
  output logic [blr_pkg::M_DATA_W-1:0]       m_axis_tdata,
  // inside_res
  output logic                               m_axis_tuser,
  output logic                               m_axis_tlast
);
  import blr_pkg::*;

  // line state
  coord_t             cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  coord_t             tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  coord_t             dx_q, dx_d, dy_q, dy_d;
  logic               dxn_q, dxn_d, dyn_q, dyn_d;
  logic [ERR_W-1:0]   err_q, err_d;
  logic [COLOR_W-1:0] color_q, color_d;
  logic               active_q, active_d;

  // output register
  logic               out_valid_q, out_valid_d;
  coord_t             out_x_q, out_y_q;
  logic [COLOR_W-1:0] out_color_q;
  logic               out_inside_q, out_last_q;

  logic               pop, is_start, emit, step_x, step_y, in_bounds, done;
  logic signed [ERR_W:0] e2, dx_ext, dy_ext;
  logic [ERR_W-1:0]   err_step;
  coord_t             x_step, y_step;

  assign deq_ready_o = !out_valid_q || m_axis_tready;

  always_comb begin
    pop      = deq_valid_i && deq_ready_o;
    is_start = (deq_data_i.cmd == CMD_START);
    emit     = pop && (is_start || active_q);

    // one Bresenham step: e2 = 2 * err
    e2       = $signed({err_q, 1'b0});
    dx_ext   = $signed({3'b000, dx_q});
    dy_ext   = $signed({3'b000, dy_q});
    step_x   = e2 > -dy_ext;
    step_y   = e2 < dx_ext;
    err_step = err_q - (step_x ? {2'b00, dy_q} : '0) + (step_y ? {2'b00, dx_q} : '0);
    x_step   = cur_x_q + (step_x ? (dxn_q ? '1 : COORD_W'(1)) : '0);
    y_step   = cur_y_q + (step_y ? (dyn_q ? '1 : COORD_W'(1)) : '0);

    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    tgt_x_d  = tgt_x_q;
    tgt_y_d  = tgt_y_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    dxn_d    = dxn_q;
    dyn_d    = dyn_q;
    err_d    = err_q;
    color_d  = color_q;
    if (pop && is_start) begin
      cur_x_d = deq_data_i.start_x;
      cur_y_d = deq_data_i.start_y;
      tgt_x_d = deq_data_i.end_x;
      tgt_y_d = deq_data_i.end_y;
      dx_d    = deq_data_i.delta_x;
      dy_d    = deq_data_i.delta_y;
      dxn_d   = deq_data_i.dir_x_neg;
      dyn_d   = deq_data_i.dir_y_neg;
      err_d   = {2'b00, deq_data_i.delta_x} - {2'b00, deq_data_i.delta_y};
      color_d = deq_data_i.color;
    end else if (emit) begin
      cur_x_d = x_step;
      cur_y_d = y_step;
      err_d   = err_step;
    end

    in_bounds = !cur_x_d[COORD_W-1] && (CMP_W'(cur_x_d) < CMP_W'(bounds_i.width)) &&
                !cur_y_d[COORD_W-1] && (CMP_W'(cur_y_d) < CMP_W'(bounds_i.height));
    done      = (cur_x_d == tgt_x_d) && (cur_y_d == tgt_y_d);

    active_d    = emit ? !done : active_q;
    out_valid_d = emit || (out_valid_q && !m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_x_q <= cur_x_d;
    cur_y_q <= cur_y_d;
    tgt_x_q <= tgt_x_d;
    tgt_y_q <= tgt_y_d;
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    dxn_q   <= dxn_d;
    dyn_q   <= dyn_d;
    err_q   <= err_d;
    color_q <= color_d;
    if (emit) begin
      out_x_q      <= cur_x_d;
      out_y_q      <= cur_y_d;
      out_color_q  <= color_d;
      out_inside_q <= in_bounds;
      out_last_q   <= done;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_DATA_W'({out_color_q, out_y_q, out_x_q});
  assign m_axis_tuser  = out_inside_q;
  assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire

// ----- rtl/core/bresenham_line_rasterizer.sv -----
// Channel   | Dir | tdata (low bit up)                        | tuser      | tlast
// s_axis    | in  | start_x, start_y, end_x, end_y, line_color | cmd        | -
// m_axis    | out | pixel_x, pixel_y, draw_color               | inside_res | last
// apb       | in  | image_width @ 0x0, image_height @ 0x4       | -          | -
//
// One request per cycle while m_axis is not stalled; one pixel per cycle out, set by
// the combinational error update and position step in the stepper.
// Path from input accept to pixel on m_axis: queue entry register, then output register.
// A two-entry queue separates the command classifier from the stepper.
// Reset clears the queue, the output valid and the line-active flag.
// A stalled m_axis holds its pixel; s_axis keeps taking requests until the queue fills.
`timescale 1ns / 1ps
`default_nettype none
module bresenham_line_rasterizer (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // start_x, start_y, end_x, end_y, line_color (low bits first)
  input  wire logic [blr_pkg::S_DATA_W-1:0]    s_axis_tdata,
  // cmd
  input  wire logic                            s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // pixel_x, pixel_y, draw_color (low bits first)
  output logic [blr_pkg::M_DATA_W-1:0]         m_axis_tdata,
  // inside_res
  output logic                                 m_axis_tuser,
  output logic                                 m_axis_tlast,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [blr_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [blr_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [blr_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                 pready
);
  import blr_pkg::*;

  blr_bounds_t bounds_q, bounds_d;
  reg_idx_e    reg_idx;
  logic        wr_en;
  logic        enq_valid, enq_ready, deq_valid, deq_ready;
  blr_cmd_t    enq_data, deq_data;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    bounds_d = bounds_q;
    if (wr_en) begin
      case (reg_idx)
        REG_IMAGE_WIDTH:  bounds_d.width  = pwdata[SIZE_W-1:0];
        REG_IMAGE_HEIGHT: bounds_d.height = pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
    case (reg_idx)
      REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(bounds_q.width);
      REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(bounds_q.height);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounds_q.width  <= IMAGE_WIDTH_RST;
      bounds_q.height <= IMAGE_HEIGHT_RST;
    end else begin
      bounds_q <= bounds_d;
    end
  end

  blr_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .enq_valid_o   (enq_valid),
    .enq_ready_i   (enq_ready),
    .enq_data_o    (enq_data)
  );

  blr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (enq_valid),
    .push_ready_o (enq_ready),
    .push_data_i  (enq_data),
    .pop_valid_o  (deq_valid),
    .pop_ready_i  (deq_ready),
    .pop_data_o   (deq_data)
  );

  blr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .bounds_i      (bounds_q),
    .deq_valid_i   (deq_valid),
    .deq_ready_o   (deq_ready),
    .deq_data_i    (deq_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
`default_nettype wire

// ----- rtl/core/blr_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module blr_props (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        m_axis_tvalid,
  input wire logic                        m_axis_tready,
  input wire logic [blr_pkg::M_DATA_W-1:0] m_axis_tdata,
  input wire logic                        m_axis_tuser,
  input wire logic                        m_axis_tlast,
  input wire logic                        pready
);
  import blr_pkg::*;

  // no pixel shows while in reset
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("pixel valid during reset");

  // stalled pixel holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled pixel changed");

  // an inside pixel never has a negative coordinate
  a_inside_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      !m_axis_tdata[COORD_W-1] && !m_axis_tdata[2*COORD_W-1])
    else $error("inside flag on negative coordinate");

  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("config port not ready");

endmodule

bind bresenham_line_rasterizer blr_props u_blr_props (.*);
`default_nettype wire
